// File: hw/rtl/price_time_order_matcher_assert.svh
// assertion macros for the order matcher
// uses the clk_i and rst_ni names of the including module
`ifndef PRICE_TIME_ORDER_MATCHER_ASSERT_SVH
`define PRICE_TIME_ORDER_MATCHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PTOM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("order matcher check failed");
`define PTOM_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("order matcher forbidden condition");
`else
`define PTOM_ASSERT(lbl, prop)
`define PTOM_NEVER(lbl, expr)
`endif
`endif

// File: hw/rtl/ptom_pkg.sv
// shared types and constants for the order matcher
// no dependencies
package ptom_pkg;

  localparam int unsigned SideDepth = 64;
  localparam int unsigned AddrW     = $clog2(SideDepth);
  localparam int unsigned CntW      = $clog2(SideDepth + 1);

  localparam logic [1:0] OP_BUY  = 2'd0;
  localparam logic [1:0] OP_SELL = 2'd1;

  typedef enum logic [2:0] {
    RES_RESTED    = 3'd0,
    RES_TRADED    = 3'd1,
    RES_CANCELLED = 3'd2,
    RES_NOT_FOUND = 3'd3,
    RES_FULL      = 3'd4
  } res_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_e;

  typedef struct packed {
    logic [31:0] ident;
    logic [31:0] price;
    logic [31:0] stamp;
    logic [31:0] seq;
  } entry_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic restart;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic found;
    logic cancel;
    logic on_ask;
    logic out_free;
  } stat_t;

  typedef struct packed {
    res_status_e status;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [31:0] trade_price;
    logic [31:0] trade_number;
    logic [6:0]  buy_depth;
    logic [6:0]  sell_depth;
  } result_t;

endpackage

// File: hw/rtl/ptom_if.sv
// valid/ready channels for order items and result items
// uses no package
interface ptom_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] order_id;
  logic [31:0] limit_price;
  logic [31:0] arrival_time;
  modport source (output valid, op, order_id, limit_price, arrival_time, input ready);
  modport sink (input valid, op, order_id, limit_price, arrival_time, output ready);
endinterface

interface ptom_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] buyer_id;
  logic [31:0] seller_id;
  logic [31:0] trade_price;
  logic [31:0] trade_number;
  logic [6:0]  buy_depth;
  logic [6:0]  sell_depth;
  modport source (output valid, status, buyer_id, seller_id, trade_price, trade_number,
                  buy_depth, sell_depth, input ready);
  modport sink (input valid, status, buyer_id, seller_id, trade_price, trade_number,
                buy_depth, sell_depth, output ready);
endinterface

// File: hw/rtl/price_time_order_matcher.sv
// top level of the price-time order matcher
// depends on ptom_pkg, ptom_if, ptom_ctrl, ptom_datapath
//
// channel  dir  handshake    payload
// in_i     in   valid/ready  op, order_id, limit_price, arrival_time
// out_o    out  valid/ready  status, ids, trade_price, trade_number, depths
//
// the block takes one item at a time: the next is accepted only after the result of
// the last is committed; the scan reads one slot per cycle, then a drain and a
// decision step follow; a cancel that misses on the buy side scans the sell side as well
// reset clears all valid bits and counters; no clearing pass is needed
// the result register frees the scan from the output; a stalled output holds
// the next item at its decision step
`include "price_time_order_matcher_assert.svh"
module price_time_order_matcher (
  input  logic clk_i,
  input  logic rst_ni,
  ptom_in_if.sink    in_i,
  ptom_out_if.source out_o
);

  ptom_pkg::cmd_t    cmd;
  ptom_pkg::stat_t   stat;
  ptom_pkg::result_t res;
  logic              res_valid;
  logic [ptom_pkg::CntW-1:0] bid_cnt, ask_cnt;
  logic              depth_over;

  ptom_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ptom_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (in_i.op),
    .order_id_i     (in_i.order_id),
    .limit_price_i  (in_i.limit_price),
    .arrival_time_i (in_i.arrival_time),
    .out_ready_i    (out_o.ready),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .bid_cnt_o      (bid_cnt),
    .ask_cnt_o      (ask_cnt)
  );

  assign out_o.valid        = res_valid;
  assign out_o.status       = res.status;
  assign out_o.buyer_id     = res.buyer_id;
  assign out_o.seller_id    = res.seller_id;
  assign out_o.trade_price  = res.trade_price;
  assign out_o.trade_number = res.trade_number;
  assign out_o.buy_depth    = res.buy_depth;
  assign out_o.sell_depth   = res.sell_depth;

  assign depth_over = (bid_cnt > ptom_pkg::CntW'(ptom_pkg::SideDepth)) ||
                      (ask_cnt > ptom_pkg::CntW'(ptom_pkg::SideDepth));

  `PTOM_ASSERT(a_one_item_at_a_time, (in_i.valid && in_i.ready) |=> !in_i.ready)
  `PTOM_NEVER(a_commit_over_result, cmd.commit && out_o.valid && !out_o.ready)
  `PTOM_NEVER(a_depth_bound, depth_over)

endmodule

// File: hw/rtl/ptom_ctrl.sv
// sequencing state machine of the order matcher
// depends on ptom_pkg
module ptom_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ptom_pkg::stat_t stat_i,
  output ptom_pkg::cmd_t  cmd_o
);

  ptom_pkg::state_e state_q, state_d;
  logic need_restart;

  // a cancel that missed on the buy side goes on to the sell side
  assign need_restart = stat_i.cancel && !stat_i.found && !stat_i.on_ask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptom_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptom_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ptom_pkg::S_SCAN;
      end
      ptom_pkg::S_SCAN: begin
        if (stat_i.last) state_d = ptom_pkg::S_DRAIN;
      end
      ptom_pkg::S_DRAIN: begin
        state_d = ptom_pkg::S_DECIDE;
      end
      ptom_pkg::S_DECIDE: begin
        if (need_restart) state_d = ptom_pkg::S_SCAN;
        else if (stat_i.out_free) state_d = ptom_pkg::S_IDLE;
      end
      default: state_d = ptom_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ptom_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ptom_pkg::S_SCAN: begin
        cmd_o.issue = 1'b1;
      end
      ptom_pkg::S_DRAIN: begin
      end
      ptom_pkg::S_DECIDE: begin
        cmd_o.restart = need_restart;
        cmd_o.commit  = !need_restart && stat_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/ptom_datapath.sv
// order book storage, best-entry scan and result register
// depends on ptom_pkg
module ptom_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        op_i,
  input  logic [31:0]       order_id_i,
  input  logic [31:0]       limit_price_i,
  input  logic [31:0]       arrival_time_i,
  input  logic              out_ready_i,
  input  ptom_pkg::cmd_t    cmd_i,
  output ptom_pkg::stat_t   stat_o,
  output logic              res_valid_o,
  output ptom_pkg::result_t res_o,
  output logic [ptom_pkg::CntW-1:0] bid_cnt_o,
  output logic [ptom_pkg::CntW-1:0] ask_cnt_o
);

  localparam int unsigned D  = ptom_pkg::SideDepth;
  localparam int unsigned AW = ptom_pkg::AddrW;
  localparam int unsigned CW = ptom_pkg::CntW;

  ptom_pkg::entry_t bid_mem [D];
  ptom_pkg::entry_t ask_mem [D];
  ptom_pkg::entry_t bid_rd_q, ask_rd_q, cand;

  logic [D-1:0]  bid_v_q, ask_v_q;
  logic [CW-1:0] bid_cnt_q, ask_cnt_q, bid_cnt_d, ask_cnt_d;
  logic [31:0]   ins_q, trade_q;
  logic [1:0]    op_q;
  logic [31:0]   id_q, lim_q, ts_q;
  logic          side_q;
  logic [AW-1:0] addr_q, rd_idx_q;
  logic          eval_q, rd_sv_q;

  logic          found_q;
  logic [AW-1:0] best_idx_q;
  logic [31:0]   best_price_q, best_time_q, best_age_q, best_ident_q;

  logic          res_valid_q;
  ptom_pkg::result_t res_q, res_d;

  logic        is_cancel, is_sell, want_high, elig, better;
  logic [31:0] age;
  logic        rest_ask, own_full, do_rest, do_remove;
  logic [AW-1:0] free_idx;
  logic [CW+6:0] bid_ext, ask_ext;

  assign is_cancel = op_q[1];
  assign is_sell   = (op_q == ptom_pkg::OP_SELL);
  assign want_high = !side_q;
  assign rest_ask  = is_sell;

  // scan compare on the entry read in the previous cycle
  always_comb begin
    cand = side_q ? ask_rd_q : bid_rd_q;
    age  = ins_q - cand.seq;
    if (is_cancel) begin
      elig   = rd_sv_q && (cand.ident == id_q);
      better = !found_q || (age > best_age_q);
    end else begin
      elig = rd_sv_q && (want_high ? (cand.price >= lim_q) : (cand.price <= lim_q));
      priority if (!found_q) better = 1'b1;
      else if (cand.price != best_price_q)
        better = want_high ? (cand.price > best_price_q) : (cand.price < best_price_q);
      else if (cand.stamp != best_time_q) better = cand.stamp < best_time_q;
      else better = age > best_age_q;
    end
  end

  // lowest free slot of the resting side
  always_comb begin
    free_idx = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (!(rest_ask ? ask_v_q[i] : bid_v_q[i])) free_idx = AW'(i);
    end
    own_full = rest_ask ? (&ask_v_q) : (&bid_v_q);
  end

  always_comb begin
    do_remove = found_q;
    do_rest   = !is_cancel && !found_q && !own_full;
    bid_cnt_d = bid_cnt_q;
    ask_cnt_d = ask_cnt_q;
    if (do_remove) begin
      if (side_q) ask_cnt_d = ask_cnt_q - CW'(1);
      else        bid_cnt_d = bid_cnt_q - CW'(1);
    end
    if (do_rest) begin
      if (rest_ask) ask_cnt_d = ask_cnt_q + CW'(1);
      else          bid_cnt_d = bid_cnt_q + CW'(1);
    end
    bid_ext = {7'd0, bid_cnt_d};
    ask_ext = {7'd0, ask_cnt_d};

    res_d = '0;
    res_d.buy_depth  = bid_ext[6:0];
    res_d.sell_depth = ask_ext[6:0];
    priority if (is_cancel) begin
      res_d.status = found_q ? ptom_pkg::RES_CANCELLED : ptom_pkg::RES_NOT_FOUND;
    end else if (found_q) begin
      res_d.status       = ptom_pkg::RES_TRADED;
      res_d.buyer_id     = is_sell ? best_ident_q : id_q;
      res_d.seller_id    = is_sell ? id_q : best_ident_q;
      res_d.trade_price  = best_price_q;
      res_d.trade_number = trade_q;
    end else if (own_full) begin
      res_d.status = ptom_pkg::RES_FULL;
    end else begin
      res_d.status = ptom_pkg::RES_RESTED;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      bid_rd_q <= bid_mem[addr_q];
      ask_rd_q <= ask_mem[addr_q];
    end
    if (cmd_i.commit && do_rest) begin
      if (rest_ask) ask_mem[free_idx] <= '{id_q, lim_q, ts_q, ins_q};
      else          bid_mem[free_idx] <= '{id_q, lim_q, ts_q, ins_q};
    end
  end

  // item latch, read index, best entry and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= op_i;
      id_q  <= order_id_i;
      lim_q <= limit_price_i;
      ts_q  <= arrival_time_i;
    end
    if (cmd_i.issue) begin
      rd_idx_q <= addr_q;
      rd_sv_q  <= side_q ? ask_v_q[addr_q] : bid_v_q[addr_q];
    end
    if (eval_q && elig && better) begin
      best_idx_q   <= rd_idx_q;
      best_price_q <= cand.price;
      best_time_q  <= cand.stamp;
      best_age_q   <= age;
      best_ident_q <= cand.ident;
    end
    if (cmd_i.commit) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q      <= 1'b0;
      addr_q      <= '0;
      eval_q      <= 1'b0;
      found_q     <= 1'b0;
      bid_v_q     <= '0;
      ask_v_q     <= '0;
      bid_cnt_q   <= '0;
      ask_cnt_q   <= '0;
      ins_q       <= '0;
      trade_q     <= 32'd1;
      res_valid_q <= 1'b0;
    end else begin
      eval_q <= cmd_i.issue;
      if (cmd_i.start) begin
        // buys scan the sell side, sells and cancels start on the buy side
        side_q  <= (op_i == ptom_pkg::OP_BUY);
        addr_q  <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.restart) begin
        side_q  <= 1'b1;
        addr_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.issue) addr_q <= AW'(addr_q + AW'(1));
        if (eval_q && elig) found_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        bid_cnt_q <= bid_cnt_d;
        ask_cnt_q <= ask_cnt_d;
        if (do_remove) begin
          if (side_q) ask_v_q[best_idx_q] <= 1'b0;
          else        bid_v_q[best_idx_q] <= 1'b0;
          if (!is_cancel) trade_q <= trade_q + 32'd1;
        end
        if (do_rest) begin
          if (rest_ask) ask_v_q[free_idx] <= 1'b1;
          else          bid_v_q[free_idx] <= 1'b1;
          ins_q <= ins_q + 32'd1;
        end
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.last     = (addr_q == AW'(D - 1));
  assign stat_o.found    = found_q;
  assign stat_o.cancel   = is_cancel;
  assign stat_o.on_ask   = side_q;
  assign stat_o.out_free = !res_valid_q || out_ready_i;
  assign res_valid_o     = res_valid_q;
  assign res_o           = res_q;
  assign bid_cnt_o       = bid_cnt_q;
  assign ask_cnt_o       = ask_cnt_q;

endmodule

// File: test/ptom_tb_if.sv
// shared testbench types and op codes
// no dependencies
package ptom_tb_pkg;

  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_CANCEL_ALT = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] order_id;
    logic [31:0] limit_price;
    logic [31:0] arrival_time;
  } order_t;
endpackage

// File: test/testbench.sv
// self-checking regression for the price-time order matcher
// depends on ptom_pkg, ptom_tb_pkg, ptom_if and price_time_order_matcher; a shadow book predicts each result
module testbench;

  localparam int unsigned N = ptom_pkg::SideDepth;
  localparam int unsigned WATCH_LIMIT = 40 * (2 * N + 8) + 2000;

  logic clk_i;
  logic rst_ni;
  ptom_in_if  in_ch ();
  ptom_out_if out_ch ();

  price_time_order_matcher DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // shadow book
  logic        bid_live [N];
  logic [31:0] bid_id   [N], bid_px [N], bid_ts [N], bid_sq [N];
  logic        ask_live [N];
  logic [31:0] ask_id   [N], ask_px [N], ask_ts [N], ask_sq [N];
  logic [31:0] ins_cnt, trade_cnt;

  ptom_pkg::result_t    pending_results [$];
  ptom_tb_pkg::order_t  script [$];
  ptom_pkg::result_t    typed_result [$];
  bit          has_typed [$];
  int          fail_count;
  int          trades_seen;
  int          idle_cycles;
  bit          stim_done;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic logic [6:0] count_live(input bit on_ask);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < N; i++) n += 7'(on_ask ? ask_live[i] : bid_live[i]);
    return n;
  endfunction

  function automatic ptom_pkg::result_t book_step(input ptom_tb_pkg::order_t o);
    ptom_pkg::result_t r;
    int k;
    bit better;
    r = '0;
    r.status = ptom_pkg::RES_RESTED;
    k = -1;
    if (o.op[1]) begin
      for (int i = 0; i < N; i++)
        if (bid_live[i] && bid_id[i] == o.order_id &&
            (k < 0 || ins_cnt - bid_sq[i] > ins_cnt - bid_sq[k])) k = i;
      if (k >= 0) begin
        bid_live[k] = 0;
        r.status = ptom_pkg::RES_CANCELLED;
      end else begin
        for (int i = 0; i < N; i++)
          if (ask_live[i] && ask_id[i] == o.order_id &&
              (k < 0 || ins_cnt - ask_sq[i] > ins_cnt - ask_sq[k])) k = i;
        if (k >= 0) begin
          ask_live[k] = 0;
          r.status = ptom_pkg::RES_CANCELLED;
        end else r.status = ptom_pkg::RES_NOT_FOUND;
      end
    end else if (o.op == ptom_pkg::OP_BUY) begin
      for (int i = 0; i < N; i++) begin
        if (!ask_live[i] || ask_px[i] > o.limit_price) continue;
        if (k < 0) begin
          k = i;
          continue;
        end
        if (ask_px[i] != ask_px[k]) better = ask_px[i] < ask_px[k];
        else if (ask_ts[i] != ask_ts[k]) better = ask_ts[i] < ask_ts[k];
        else better = (ins_cnt - ask_sq[i]) > (ins_cnt - ask_sq[k]);
        if (better) k = i;
      end
      if (k >= 0) begin
        r.status = ptom_pkg::RES_TRADED;
        r.buyer_id = o.order_id;
        r.seller_id = ask_id[k];
        r.trade_price = ask_px[k];
        r.trade_number = trade_cnt++;
        ask_live[k] = 0;
      end else begin
        for (int i = 0; i < N; i++) if (!bid_live[i]) begin
          k = i;
          break;
        end
        if (k < 0) r.status = ptom_pkg::RES_FULL;
        else begin
          bid_live[k] = 1; bid_id[k] = o.order_id; bid_px[k] = o.limit_price;
          bid_ts[k] = o.arrival_time; bid_sq[k] = ins_cnt++;
        end
      end
    end else begin
      for (int i = 0; i < N; i++) begin
        if (!bid_live[i] || bid_px[i] < o.limit_price) continue;
        if (k < 0) begin
          k = i;
          continue;
        end
        if (bid_px[i] != bid_px[k]) better = bid_px[i] > bid_px[k];
        else if (bid_ts[i] != bid_ts[k]) better = bid_ts[i] < bid_ts[k];
        else better = (ins_cnt - bid_sq[i]) > (ins_cnt - bid_sq[k]);
        if (better) k = i;
      end
      if (k >= 0) begin
        r.status = ptom_pkg::RES_TRADED;
        r.buyer_id = bid_id[k];
        r.seller_id = o.order_id;
        r.trade_price = bid_px[k];
        r.trade_number = trade_cnt++;
        bid_live[k] = 0;
      end else begin
        for (int i = 0; i < N; i++) if (!ask_live[i]) begin
          k = i;
          break;
        end
        if (k < 0) r.status = ptom_pkg::RES_FULL;
        else begin
          ask_live[k] = 1; ask_id[k] = o.order_id; ask_px[k] = o.limit_price;
          ask_ts[k] = o.arrival_time; ask_sq[k] = ins_cnt++;
        end
      end
    end
    r.buy_depth = count_live(1'b0);
    r.sell_depth = count_live(1'b1);
    return r;
  endfunction

  function automatic int short_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  function automatic ptom_tb_pkg::order_t make_order(input logic [1:0] op,
                                                     input logic [31:0] id,
                                                     input logic [31:0] px,
                                                     input logic [31:0] ts);
    ptom_tb_pkg::order_t o;
    o.op = op; o.order_id = id; o.limit_price = px; o.arrival_time = ts;
    return o;
  endfunction

  task automatic add_row(input ptom_tb_pkg::order_t o, input bit typed,
                         input ptom_pkg::result_t r);
    script.push_back(o);
    has_typed.push_back(typed);
    typed_result.push_back(r);
  endtask

  // random item with small id and price pools so trades and cancels hit often
  function automatic ptom_tb_pkg::order_t rand_order(input int mode);
    ptom_tb_pkg::order_t o;
    o.op = $urandom_range(0, 9) < 4 ? ptom_pkg::OP_BUY :
           ($urandom_range(0, 5) < 4 ? ptom_pkg::OP_SELL :
           ($urandom_range(0, 1) ? ptom_tb_pkg::OP_CANCEL : ptom_tb_pkg::OP_CANCEL_ALT));
    o.order_id = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 40);
    o.limit_price = ($urandom_range(0, 9) == 0) ? $urandom() : 1000 + $urandom_range(0, 20);
    o.arrival_time = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 30);
    // fill phases push one side toward full
    if (mode == 1 && o.op != ptom_pkg::OP_SELL) begin
      o.op = ptom_pkg::OP_BUY; o.limit_price = $urandom_range(0, 500);
    end
    if (mode == 2 && o.op != ptom_pkg::OP_BUY) begin
      o.op = ptom_pkg::OP_SELL; o.limit_price = 32'hffff_0000 + $urandom_range(0, 500);
    end
    return o;
  endfunction

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // sender
  initial begin
    ptom_pkg::result_t r0;
    ptom_tb_pkg::order_t o;
    int mode;
    in_ch.valid = 0; in_ch.op = ptom_pkg::OP_BUY; in_ch.order_id = 0;
    in_ch.limit_price = 0; in_ch.arrival_time = 0;
    rst_ni = 0;
    fail_count = 0; stim_done = 0;
    for (int i = 0; i < N; i++) begin
      bid_live[i] = 0; ask_live[i] = 0;
    end
    ins_cnt = 0; trade_cnt = 1;

    r0 = '0;
    // directed rows: typed results where obvious, else predicted
    r0.status = ptom_pkg::RES_NOT_FOUND;
    add_row(make_order(ptom_tb_pkg::OP_CANCEL, 32'h0, 0, 0), 1, r0);
    add_row(make_order(ptom_tb_pkg::OP_CANCEL_ALT, 32'hffff_ffff, 0, 0), 1, r0);
    r0.status = ptom_pkg::RES_RESTED; r0.buy_depth = 1;
    add_row(make_order(ptom_pkg::OP_BUY, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff), 1, r0);
    r0 = '0; r0.status = ptom_pkg::RES_TRADED; r0.buyer_id = 32'hffff_ffff;
    r0.trade_price = 32'hffff_ffff; r0.trade_number = 1;
    add_row(make_order(ptom_pkg::OP_SELL, 32'h0, 32'h0, 32'h0), 1, r0);
    add_row(make_order(ptom_pkg::OP_SELL, 7, 100, 5), 0, r0);
    add_row(make_order(ptom_pkg::OP_SELL, 8, 100, 3), 0, r0);
    add_row(make_order(ptom_pkg::OP_SELL, 9, 100, 3), 0, r0);
    add_row(make_order(ptom_pkg::OP_SELL, 7, 90, 9), 0, r0);
    add_row(make_order(ptom_pkg::OP_BUY, 1, 50, 0), 0, r0);
    add_row(make_order(ptom_pkg::OP_BUY, 2, 100, 0), 0, r0);
    add_row(make_order(ptom_pkg::OP_BUY, 3, 100, 0), 0, r0);
    add_row(make_order(ptom_pkg::OP_BUY, 4, 100, 0), 0, r0);
    add_row(make_order(ptom_pkg::OP_BUY, 5, 60, 1), 0, r0);
    add_row(make_order(ptom_pkg::OP_BUY, 5, 60, 1), 0, r0);
    add_row(make_order(ptom_pkg::OP_SELL, 6, 60, 0), 0, r0);
    add_row(make_order(ptom_tb_pkg::OP_CANCEL, 5, 0, 0), 0, r0);
    add_row(make_order(ptom_tb_pkg::OP_CANCEL_ALT, 7, 0, 0), 0, r0);
    add_row(make_order(ptom_tb_pkg::OP_CANCEL, 1, 32'hffff_ffff, 32'hffff_ffff), 0, r0);
    add_row(make_order(ptom_pkg::OP_SELL, 32'haaaa_5555, 32'h5555_aaaa, 32'haaaa_5555), 0, r0);
    add_row(make_order(ptom_pkg::OP_BUY, 32'h5555_aaaa, 32'h0, 32'h5555_aaaa), 0, r0);
    add_row(make_order(ptom_tb_pkg::OP_CANCEL, 32'haaaa_5555, 0, 0), 0, r0);
    add_row(make_order(ptom_tb_pkg::OP_CANCEL, 32'h5555_aaaa, 0, 0), 0, r0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    for (int n = 0; n < 1450; n++) begin
      if (n < script.size()) o = script[n];
      else begin
        mode = 0;
        if (n >= 300 && n < 420) mode = 1;  // fill the buy side past full
        if (n >= 700 && n < 820) mode = 2;  // fill the sell side past full
        o = rand_order(mode);
      end
      if (n == script.size() || n == 900) begin
        // hold off until the block has delivered everything
        in_ch.valid <= 0;
        wait (pending_results.size() == 0);
        @(negedge clk_i);
      end
      begin
        ptom_pkg::result_t pr;
        pr = book_step(o);
        if (n < script.size() && has_typed[n]) begin
          if (pr !== typed_result[n])
            report_mismatch($sformatf("directed row %0d", n), 32'(pr.status),
                            32'(typed_result[n].status));
          pr = typed_result[n];
        end
        pending_results.push_back(pr);
      end
      in_ch.op <= o.op; in_ch.order_id <= o.order_id;
      in_ch.limit_price <= o.limit_price; in_ch.arrival_time <= o.arrival_time;
      in_ch.valid <= 1;
      @(posedge clk_i);
      while (!in_ch.ready) @(posedge clk_i);
      @(negedge clk_i);
      if (n >= script.size() && (n % 200) > 150) continue;  // burst stretch
      begin
        int g;
        g = short_gap();
        if (g > 0) begin
          in_ch.valid <= 0;
          repeat (g) @(negedge clk_i);
        end
      end
    end
    in_ch.valid <= 0;
    stim_done = 1;
  end

  // receiver with random stalls
  initial begin
    int g;
    out_ch.ready = 0;
    forever begin
      @(negedge clk_i);
      g = ($urandom_range(0, 1) == 0 || (($time / 5000) % 4 == 0)) ? 0 : short_gap();
      if (g > 0) begin
        out_ch.ready <= 0;
        repeat (g) @(negedge clk_i);
      end
      out_ch.ready <= 1;
    end
  end

  // checker
  always @(posedge clk_i) begin
    ptom_pkg::result_t w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item", 32'(out_ch.status), '0);
      end else begin
        w = pending_results.pop_front();
        if (out_ch.status !== w.status)
          report_mismatch("status", 32'(out_ch.status), 32'(w.status));
        if (out_ch.buyer_id !== w.buyer_id)
          report_mismatch("buyer_id", out_ch.buyer_id, w.buyer_id);
        if (out_ch.seller_id !== w.seller_id)
          report_mismatch("seller_id", out_ch.seller_id, w.seller_id);
        if (out_ch.trade_price !== w.trade_price)
          report_mismatch("trade_price", out_ch.trade_price, w.trade_price);
        if (out_ch.trade_number !== w.trade_number)
          report_mismatch("trade_number", out_ch.trade_number, w.trade_number);
        if (out_ch.buy_depth !== w.buy_depth)
          report_mismatch("buy_depth", 32'(out_ch.buy_depth), 32'(w.buy_depth));
        if (out_ch.sell_depth !== w.sell_depth)
          report_mismatch("sell_depth", 32'(out_ch.sell_depth), 32'(w.sell_depth));
        if (w.status == ptom_pkg::RES_TRADED) trades_seen++;
      end
    end
  end

  // watchdog and end of run
  initial begin
    trades_seen = 0;
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (stim_done && pending_results.size() == 0) break;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending_results.size());
        $display("price_time_order_matcher regression: fail");
        $finish;
      end
    end
    repeat (4 * N) @(posedge clk_i);
    $display("covered 1450 items: buys, sells, cancels incl. op 3, full sides, duplicate ids");
    $display("%0d trades checked against the shadow book", trades_seen);
    if (fail_count == 0) $display("price_time_order_matcher regression: pass");
    else $display("price_time_order_matcher regression: fail");
    $finish;
  end
endmodule
